// ===== rtl/ufmt_pkg.sv =====
// Shared types and constants for the unsigned to ASCII formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ufmt_pkg;

	// conversion modes carried in the input tuser field
	localparam logic [1:0] MODE_DEC    = 2'd0;
	localparam logic [1:0] MODE_HEX_LO = 2'd1;
	localparam logic [1:0] MODE_HEX_UP = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// character set
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_F = 8'h46;
	localparam logic [7:0] CHAR_LO_F = 8'h66;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// digit slots held for one run
	localparam int unsigned RUN_MAX  = 16;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned BCD_W    = RUN_MAX * DIGIT_W;
	localparam int unsigned REM_W    = $clog2(RUN_MAX + 1);

	// controller state, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} ufmt_state_t;

	// controls from the sequencer to the digit register
	typedef struct packed {
		logic load;   // start a new conversion
		logic step;   // shift one source bit into the digit register
		logic dec;    // apply the decimal add-3 correction on a step
		logic pop;    // drop the leading digit
	} ufmt_ctrl_t;

	// ASCII character for one digit
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CHAR_UP_A : CHAR_LO_A;
		if (d <= 4'd9)
			return CHAR_ZERO + {4'b0000, d};
		else
			return base + {4'b0000, d} - 8'd10;
	endfunction

endpackage

// ===== rtl/unsigned_to_ascii_formatter.sv =====
// Top level of the unsigned to ASCII formatter: sequencer, character counter, output register.
// Depends on ufmt_pkg and ufmt_digits.
`timescale 1ns / 1ps

// Formats one unsigned value per transaction as ASCII digits, most significant first,
// without leading zeros (zero gives a single '0'); tuser selects decimal (low DEC_WIDTH
// bits), lower-case hex or upper-case hex (low HEX_WIDTH bits), and mode 3 is dropped.
// Each character leaves with a running 32-bit count of all characters sent, and tlast
// marks the end of a number. One number is worked on at a time: after acceptance the
// value passes bit-serially through a shift-and-add-3 digit register (add-3 in decimal
// mode only), one bit per cycle, then the 16 digit slots are scanned, skipping leading
// zeros and sending one character per cycle while the sink is ready. Decimal values with
// more than 16 digits give their 16 least significant digits, leading zeros included.
module unsigned_to_ascii_formatter #(
	parameter int unsigned DEC_WIDTH = 32,
	parameter int unsigned HEX_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] ascii_char, [39:8] total_count
	output logic        m_tlast    // last_char
);
	import ufmt_pkg::*;

	localparam int unsigned SRC_W = (DEC_WIDTH > HEX_WIDTH) ? DEC_WIDTH : HEX_WIDTH;
	localparam int unsigned CNT_W = $clog2(SRC_W + 1);

	ufmt_state_t         state_q;
	logic [CNT_W-1:0]    bits_q;
	logic [REM_W-1:0]    rem_q;
	logic                dec_q;
	logic                upper_q;
	logic                started_q;
	logic [31:0]         count_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_last_q;
	logic [31:0]         out_count_q;

	ufmt_ctrl_t          ctrl;
	logic [SRC_W-1:0]    load_value;
	logic [DIGIT_W-1:0]  top_digit;
	logic                ovf;
	logic                in_fire;
	logic                out_free;
	logic                skip;
	logic                emit;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready && (s_tuser != MODE_NONE);
	assign out_free = !out_valid_q || m_tready;

	// leading zero skip, not once the value overflowed the 16 slots
	assign skip = (state_q == ST_EMIT) && !started_q && !ovf
		&& (top_digit == '0) && (rem_q != REM_W'(1));
	assign emit = (state_q == ST_EMIT) && !skip && out_free;

	// source value aligned to the top of the shift register
	always_comb begin
		if (s_tuser == MODE_DEC)
			load_value = SRC_W'(s_tdata[DEC_WIDTH-1:0]) << (SRC_W - DEC_WIDTH);
		else
			load_value = SRC_W'(s_tdata[HEX_WIDTH-1:0]) << (SRC_W - HEX_WIDTH);
	end

	// digit register controls
	always_comb begin
		ctrl.load = in_fire;
		ctrl.step = (state_q == ST_CONV);
		ctrl.dec  = dec_q;
		ctrl.pop  = skip || emit;
	end

	ufmt_digits #(
		.SRC_W(SRC_W)
	) u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_value(load_value),
		.top_digit (top_digit),
		.ovf       (ovf)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bits_q    <= '0;
			rem_q     <= '0;
			dec_q     <= 1'b0;
			upper_q   <= 1'b0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q   <= ST_CONV;
						dec_q     <= (s_tuser == MODE_DEC);
						upper_q   <= (s_tuser == MODE_HEX_UP);
						bits_q    <= (s_tuser == MODE_DEC) ? CNT_W'(DEC_WIDTH)
							: CNT_W'(HEX_WIDTH);
						rem_q     <= REM_W'(RUN_MAX);
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					bits_q <= bits_q - 1'b1;
					if (bits_q == CNT_W'(1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (skip) begin
						rem_q <= rem_q - 1'b1;
					end else if (emit) begin
						rem_q     <= rem_q - 1'b1;
						started_q <= 1'b1;
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// running character count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				count_q     <= count_q + 32'd1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q  <= digit_char(top_digit, upper_q);
			out_last_q  <= (rem_q == REM_W'(1));
			out_count_q <= count_q + 32'd1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/ufmt_digits.sv =====
// Bit-serial digit register: source shift register plus 16-digit shift-and-add-3 store.
// Depends on ufmt_pkg.
`timescale 1ns / 1ps

module ufmt_digits #(
	parameter int unsigned SRC_W = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ufmt_pkg::ufmt_ctrl_t       ctrl,
	input  logic [SRC_W-1:0]           load_value,
	output logic [ufmt_pkg::DIGIT_W-1:0] top_digit,
	output logic                       ovf
);
	import ufmt_pkg::*;

	logic [SRC_W-1:0]   src_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               ovf_q;
	logic [BCD_W-1:0]   bcd_fix;

	// add-3 correction, in decimal mode only, on every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < RUN_MAX; i++) begin
			if (ctrl.dec && bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5)
				bcd_fix[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			else
				bcd_fix[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	// overflow flag: cleared on load, set when a step shifts a one out of the top digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctrl.load) begin
			ovf_q <= 1'b0;
		end else if (ctrl.step && bcd_fix[BCD_W-1]) begin
			ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			src_q <= load_value;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			src_q <= {src_q[SRC_W-2:0], 1'b0};
			bcd_q <= {bcd_fix[BCD_W-2:0], src_q[SRC_W-1]};
		end else if (ctrl.pop) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign ovf       = ovf_q;

endmodule

// ===== rtl/ufmt_checker.sv =====
// Port-level checks for the unsigned to ASCII formatter, bound to the top level.
// Depends on ufmt_pkg and unsigned_to_ascii_formatter.
`timescale 1ns / 1ps

module ufmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);
	import ufmt_pkg::*;

	// a stalled transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// only digit characters leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] >= CHAR_ZERO && m_tdata[7:0] <= CHAR_NINE)
			|| (m_tdata[7:0] >= CHAR_LO_A && m_tdata[7:0] <= CHAR_LO_F)
			|| (m_tdata[7:0] >= CHAR_UP_A && m_tdata[7:0] <= CHAR_UP_F))
		else $error("output is not a digit character");

	// a real conversion keeps the input closed on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_NONE |=> !s_tready)
		else $error("input reopened during a conversion");

	// while the input is open, a waiting character ends its run
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("input open in the middle of a run");

	// consecutive characters count up by one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid |-> m_tdata[39:8] == $past(m_tdata[39:8]) + 32'd1)
		else $error("character count skipped");

endmodule

bind unsigned_to_ascii_formatter ufmt_checker u_ufmt_checker (.*);
